### hdl/bidt_pkg.sv
`default_nettype none

package bidt_pkg;

  localparam int FuncW = 3;
  localparam int IdW   = 4;
  localparam int PcW   = 16;
  localparam int ValW  = 16;

  typedef enum logic [FuncW-1:0] {
    OP_ALLOC  = 3'd0,
    OP_RETIRE = 3'd1,
    OP_RECORD = 3'd2,
    OP_UPDATE = 3'd3,
    OP_LOOKUP = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIND,
    ST_SHIFT,
    ST_LOOK,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clr;
    logic inc;
    logic shift;
    logic retire;
    logic upd;
    logic hit;
    logic fail;
    logic put;
  } dp_cmd_t;

  typedef struct packed {
    op_t  func;
    logic ord_end;
    logic ord_hit;
    logic shift_last;
    logic free_full;
    logic look_end;
    logic look_hit;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/bidt_ifs.sv
`default_nettype none

interface bidt_in_if import bidt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [FuncW-1:0]     func;
  logic [IdW-1:0]       branch_id;
  logic [PcW-1:0]       branch_pc;
  logic [ValW-1:0]      predicted_value;

  modport source (output valid, func, branch_id, branch_pc, predicted_value, input ready);
  modport sink   (input valid, func, branch_id, branch_pc, predicted_value, output ready);
endinterface

interface bidt_out_if import bidt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [IdW-1:0]       given_id;
  logic [ValW-1:0]      found_value;
  logic [IdW-1:0]       recent_id;

  modport source (output valid, ok, given_id, found_value, recent_id, input ready);
  modport sink   (input valid, ok, given_id, found_value, recent_id, output ready);
endinterface

`default_nettype wire

### hdl/branch_id_allocator_and_target_table_core.sv
// Channel  Dir  Word
// in_ch    in   func, branch_id, branch_pc, predicted_value
// out_ch   out  ok, given_id, found_value, recent_id
//
// One word at a time: alloc, record and unknown codes go from ST_EXEC to ST_PUT;
// update scans the order list in ST_FIND for the matching place, lookup the
// table in ST_LOOK for the first matching row (a miss scans the whole list or
// table); retire finds its entry in ST_FIND, then shifts later ones in ST_SHIFT.
// rst_n is synchronous; the free list comes up holding 1..NUM_IDS in order.
// A result held by out_ch.ready does not block the next input word.
`default_nettype none

module branch_id_allocator_and_target_table_core import bidt_pkg::*; #(
  parameter int NUM_IDS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bidt_in_if.sink     in_ch,
  bidt_out_if.source  out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bidt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bidt_dp #(
    .NUM_IDS (NUM_IDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_func            (in_ch.func),
    .in_branch_id       (in_ch.branch_id),
    .in_branch_pc       (in_ch.branch_pc),
    .in_predicted_value (in_ch.predicted_value),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_ok             (out_ch.ok),
    .out_given_id       (out_ch.given_id),
    .out_found_value    (out_ch.found_value),
    .out_recent_id      (out_ch.recent_id)
  );

endmodule

`default_nettype wire

### hdl/bidt_ctrl.sv
`default_nettype none

module bidt_ctrl import bidt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.func) inside
          OP_RETIRE, OP_UPDATE: state_nxt = ST_FIND;
          OP_LOOKUP:            state_nxt = ST_LOOK;
          default:              state_nxt = ST_PUT;
        endcase
      end
      ST_FIND: begin
        if (sts.ord_end) begin
          state_nxt = ST_PUT;
        end else if (sts.ord_hit) begin
          if (sts.func == OP_RETIRE && !sts.free_full) state_nxt = ST_SHIFT;
          else state_nxt = ST_PUT;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_last) state_nxt = ST_PUT;
      end
      ST_LOOK: begin
        if (sts.look_end || sts.look_hit) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        case (sts.func) inside
          OP_RETIRE, OP_UPDATE, OP_LOOKUP: cmd.clr = 1'b1;
          default:                         cmd.exec = 1'b1;
        endcase
      end
      ST_FIND: begin
        if (sts.ord_end) begin
          cmd.fail = 1'b1;
        end else if (sts.ord_hit) begin
          if (sts.func == OP_RETIRE) cmd.fail = sts.free_full;
          else cmd.upd = 1'b1;
        end else begin
          cmd.inc = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_last) begin
          cmd.retire = 1'b1;
        end else begin
          cmd.shift = 1'b1;
          cmd.inc   = 1'b1;
        end
      end
      ST_LOOK: begin
        if (sts.look_end) cmd.fail = 1'b1;
        else if (sts.look_hit) cmd.hit = 1'b1;
        else cmd.inc = 1'b1;
      end
      ST_PUT: begin
        cmd.put = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/bidt_dp.sv
`default_nettype none

module bidt_dp import bidt_pkg::*; #(
  parameter int NUM_IDS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [FuncW-1:0] in_func,
  input  wire logic [IdW-1:0]   in_branch_id,
  input  wire logic [PcW-1:0]   in_branch_pc,
  input  wire logic [ValW-1:0]  in_predicted_value,
  input  wire dp_cmd_t          cmd,
  output dp_sts_t               sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_ok,
  output logic [IdW-1:0]        out_given_id,
  output logic [ValW-1:0]       out_found_value,
  output logic [IdW-1:0]        out_recent_id
);

  localparam int IW = $clog2(NUM_IDS);
  localparam int CW = $clog2(NUM_IDS + 1);

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == IW'(NUM_IDS - 1)) ? '0 : p + IW'(1);
  endfunction

  op_t              func_r;
  logic [IdW-1:0]   id_r;
  logic [PcW-1:0]   pc_r;
  logic [ValW-1:0]  val_r;

  logic [IdW-1:0]   free_mem_r [NUM_IDS];
  logic [IW-1:0]    head_r, tail_r;
  logic [CW-1:0]    free_cnt_r;
  logic [IdW-1:0]   ord_mem_r [NUM_IDS];
  logic [CW-1:0]    ord_cnt_r;
  logic [PcW-1:0]   ent_pc_r [NUM_IDS];
  logic [ValW-1:0]  ent_val_r [NUM_IDS];
  logic [NUM_IDS-1:0] ent_vld_r;
  logic [IdW-1:0]   latest_r;
  logic [CW-1:0]    idx_r;

  logic             res_ok_r;
  logic [IdW-1:0]   res_given_r;
  logic [ValW-1:0]  res_found_r;

  logic             out_vld_r;
  logic             out_ok_r;
  logic [IdW-1:0]   out_given_r;
  logic [ValW-1:0]  out_found_r;
  logic [IdW-1:0]   out_recent_r;

  logic [IW-1:0]    idx_lo;
  logic [CW-1:0]    idx_nx;
  logic [IdW-1:0]   id_m1;
  logic [IW-1:0]    upd_idx;
  logic             in_tab;
  logic             alloc_ok;
  logic             rec_ok;

  assign idx_lo   = idx_r[IW-1:0];
  assign idx_nx   = idx_r + CW'(1);
  assign id_m1    = id_r - IdW'(1);
  assign upd_idx  = id_m1[IW-1:0];
  assign in_tab   = idx_r < CW'(NUM_IDS);
  assign alloc_ok = free_cnt_r != '0;
  assign rec_ok   = (id_r != '0) && (id_r <= IdW'(NUM_IDS)) && (ord_cnt_r < CW'(NUM_IDS));

  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.ord_end    = idx_r >= ord_cnt_r;
    sts.ord_hit    = !sts.ord_end && (ord_mem_r[idx_lo] == id_r);
    sts.shift_last = idx_nx >= ord_cnt_r;
    sts.free_full  = free_cnt_r == CW'(NUM_IDS);
    sts.look_end   = !in_tab;
    sts.look_hit   = in_tab && ent_vld_r[idx_lo] && (ent_pc_r[idx_lo] == pc_r);
    sts.out_free   = !out_vld_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_IDS; i++) begin
        free_mem_r[i] <= IdW'(i + 1);
      end
      head_r     <= '0;
      tail_r     <= '0;
      free_cnt_r <= CW'(NUM_IDS);
      ord_cnt_r  <= '0;
      ent_vld_r  <= '0;
      latest_r   <= '0;
      idx_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (func_r)
          OP_ALLOC: begin
            if (alloc_ok) begin
              head_r     <= wrap_inc(head_r);
              free_cnt_r <= free_cnt_r - CW'(1);
            end
          end
          OP_RECORD: begin
            if (rec_ok) begin
              ord_cnt_r <= ord_cnt_r + CW'(1);
              latest_r  <= id_r;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.clr) idx_r <= '0;
      if (cmd.inc) idx_r <= idx_nx;
      if (cmd.retire) begin
        ord_cnt_r          <= ord_cnt_r - CW'(1);
        free_mem_r[tail_r] <= id_r;
        tail_r             <= wrap_inc(tail_r);
        free_cnt_r         <= free_cnt_r + CW'(1);
      end
      if (cmd.upd) ent_vld_r[upd_idx] <= 1'b1;
      if (cmd.put) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= op_t'(in_func);
      id_r   <= in_branch_id;
      pc_r   <= in_branch_pc;
      val_r  <= in_predicted_value;
    end
    if (cmd.exec) begin
      case (func_r)
        OP_ALLOC: begin
          res_ok_r    <= alloc_ok;
          res_given_r <= alloc_ok ? free_mem_r[head_r] : '0;
          res_found_r <= '0;
        end
        OP_RECORD: begin
          res_ok_r    <= rec_ok;
          res_given_r <= '0;
          res_found_r <= '0;
          if (rec_ok) ord_mem_r[ord_cnt_r[IW-1:0]] <= id_r;
        end
        default: begin
          res_ok_r    <= 1'b0;
          res_given_r <= '0;
          res_found_r <= '0;
        end
      endcase
    end
    if (cmd.shift) ord_mem_r[idx_lo] <= ord_mem_r[idx_nx[IW-1:0]];
    if (cmd.upd) begin
      ent_pc_r[upd_idx]  <= pc_r;
      ent_val_r[upd_idx] <= val_r;
    end
    if (cmd.fail) begin
      res_ok_r    <= 1'b0;
      res_given_r <= '0;
      res_found_r <= '0;
    end
    if (cmd.retire || cmd.upd) begin
      res_ok_r    <= 1'b1;
      res_given_r <= '0;
      res_found_r <= '0;
    end
    if (cmd.hit) begin
      res_ok_r    <= 1'b1;
      res_given_r <= '0;
      res_found_r <= ent_val_r[idx_lo];
    end
    if (cmd.put) begin
      out_ok_r     <= res_ok_r;
      out_given_r  <= res_given_r;
      out_found_r  <= res_found_r;
      out_recent_r <= latest_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_ok          = out_ok_r;
  assign out_given_id    = out_given_r;
  assign out_found_value = out_found_r;
  assign out_recent_id   = out_recent_r;

endmodule

`default_nettype wire

### hdl/bidt_chk.sv
`default_nettype none

module bidt_chk import bidt_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic            out_ok,
  input wire logic [IdW-1:0]  out_given_id,
  input wire logic [ValW-1:0] out_found_value,
  input wire logic [IdW-1:0]  out_recent_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_given_id)
      && $stable(out_found_value) && $stable(out_recent_id))
    else $error("result word changed while stalled");

  a_given_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_given_id != '0 |-> out_ok && out_found_value == '0)
    else $error("handed-out ID without success");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_value != '0 |-> out_ok && out_given_id == '0)
    else $error("found value without lookup hit");

endmodule

bind branch_id_allocator_and_target_table_core bidt_chk u_bidt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ok          (out_ch.ok),
  .out_given_id    (out_ch.given_id),
  .out_found_value (out_ch.found_value),
  .out_recent_id   (out_ch.recent_id)
);

`default_nettype wire

### tb/tb_branch_id_allocator_and_target_table_core.sv
module tb_branch_id_allocator_and_target_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bidt_pkg::*;

  localparam int NUM_IDS       = 8;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int SETTLE_CYCLES = 2 * NUM_IDS + 8;
  localparam int PC_POOL_SIZE  = 4;
  localparam logic [IdW-1:0] NO_ID = '0;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IdW-1:0]   id;
    logic [PcW-1:0]   pc;
    logic [ValW-1:0]  val;
  } branch_req_t;

  typedef struct packed {
    logic            ok;
    logic [IdW-1:0]  given_id;
    logic [ValW-1:0] found_value;
    logic [IdW-1:0]  recent_id;
  } branch_rsp_t;

  logic clk;
  logic rst_n;

  bidt_in_if  in_ch ();
  bidt_out_if out_ch ();

  branch_id_allocator_and_target_table_core #(
    .NUM_IDS(NUM_IDS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow state of the block
  logic [IdW-1:0]  free_fifo [NUM_IDS];
  int              free_cnt;
  logic [IdW-1:0]  in_flight [NUM_IDS];
  int              flight_cnt;
  logic [PcW-1:0]  tgt_pc    [NUM_IDS];
  logic [ValW-1:0] tgt_val   [NUM_IDS];
  logic            tgt_vld   [NUM_IDS];
  logic [IdW-1:0]  last_recorded;

  branch_rsp_t     pending_results [$];
  logic [IdW-1:0]  unrecorded_ids [$];
  logic [PcW-1:0]  pc_pool [PC_POOL_SIZE];

  int src_idle_pct;
  int snk_idle_pct;
  int hold_request;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_in_flight(logic [IdW-1:0] id);
    int i;
    for (i = 0; i < flight_cnt; i++) begin
      if (in_flight[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic branch_rsp_t exec_branch_op(branch_req_t req);
    branch_rsp_t rsp;
    int          pos;
    int          i;
    rsp = '0;
    case (req.func)
      OP_ALLOC: begin
        if (free_cnt > 0) begin
          rsp.given_id = free_fifo[0];
          for (i = 1; i < free_cnt; i++) free_fifo[i-1] = free_fifo[i];
          free_cnt--;
          rsp.ok = 1'b1;
        end
      end
      OP_RETIRE: begin
        pos = find_in_flight(req.id);
        if (pos >= 0 && free_cnt < NUM_IDS) begin
          for (i = pos + 1; i < flight_cnt; i++) in_flight[i-1] = in_flight[i];
          flight_cnt--;
          free_fifo[free_cnt] = req.id;
          free_cnt++;
          rsp.ok = 1'b1;
        end
      end
      OP_RECORD: begin
        if (req.id >= 1 && req.id <= NUM_IDS && flight_cnt < NUM_IDS) begin
          in_flight[flight_cnt] = req.id;
          flight_cnt++;
          last_recorded = req.id;
          rsp.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (req.id >= 1 && req.id <= NUM_IDS && find_in_flight(req.id) >= 0) begin
          tgt_pc[req.id-1]  = req.pc;
          tgt_val[req.id-1] = req.val;
          tgt_vld[req.id-1] = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_LOOKUP: begin
        for (i = 0; i < NUM_IDS; i++) begin
          if (!rsp.ok && tgt_vld[i] && tgt_pc[i] == req.pc) begin
            rsp.found_value = tgt_val[i];
            rsp.ok = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.recent_id = last_recorded;
    return rsp;
  endfunction

  task automatic send_word(logic [FuncW-1:0] func, logic [IdW-1:0] id,
                           logic [PcW-1:0] pc, logic [ValW-1:0] val);
    branch_req_t req;
    branch_rsp_t rsp;
    req = '{func: func, id: id, pc: pc, val: val};
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= req.func;
    in_ch.branch_id       <= req.id;
    in_ch.branch_pc       <= req.pc;
    in_ch.predicted_value <= req.val;
    do @(posedge clk); while (!in_ch.ready);
    rsp = exec_branch_op(req);
    pending_results = {pending_results, rsp};
    if (req.func == OP_ALLOC && rsp.ok) unrecorded_ids = {unrecorded_ids, rsp.given_id};
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_rejects();
    send_word(OP_LOOKUP, NO_ID, '0, '0);
    for (int f = OP_LOOKUP + 1; f < 2**FuncW; f++) send_word(FuncW'(f), '1, '1, '1);
    send_word(OP_UPDATE, 4'd2, 16'h1234, 16'h5678);
    send_word(OP_RECORD, NO_ID, '0, '0);
    send_word(OP_RECORD, '1, '1, '1);
    send_word(OP_RECORD, IdW'(NUM_IDS), '0, '0);
    // free list still full, so this retire must bounce
    send_word(OP_RETIRE, IdW'(NUM_IDS), '0, '0);
  endtask

  task automatic test_alloc_exhaust();
    repeat (NUM_IDS + 1) send_word(OP_ALLOC, '1, '1, '1);
  endtask

  task automatic test_order_fill();
    for (int i = 1; i < NUM_IDS; i++) send_word(OP_RECORD, IdW'(i), '0, '0);
    send_word(OP_RECORD, 4'd3, '0, '0);
  endtask

  task automatic test_table();
    send_word(OP_UPDATE, IdW'(NUM_IDS), '1, '1);
    send_word(OP_UPDATE, 4'd1, '0, 16'hA5C3);
    send_word(OP_LOOKUP, NO_ID, '1, '0);
    send_word(OP_LOOKUP, NO_ID, '0, '1);
    send_word(OP_RETIRE, IdW'(NUM_IDS), '0, '0);
    send_word(OP_RETIRE, IdW'(NUM_IDS), '0, '0);
  endtask

  task automatic test_random(int count, int src_pct, int snk_pct);
    int              pick;
    logic [IdW-1:0]  id;
    logic [PcW-1:0]  pc;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int i = 0; i < PC_POOL_SIZE; i++) pc_pool[i] = PcW'($urandom);
    repeat (count) begin
      pick = $urandom_range(99);
      id   = (flight_cnt > 0) ? in_flight[$urandom_range(flight_cnt - 1)]
                              : IdW'($urandom_range(NUM_IDS, 1));
      pc   = ($urandom_range(9) < 8) ? pc_pool[$urandom_range(PC_POOL_SIZE - 1)]
                                     : PcW'($urandom);
      if (pick < 18) begin
        send_word(OP_ALLOC, IdW'($urandom), PcW'($urandom), ValW'($urandom));
      end else if (pick < 38) begin
        if (unrecorded_ids.size() != 0) begin
          id = unrecorded_ids[0];
          unrecorded_ids.delete(0);
        end else begin
          id = IdW'($urandom_range(NUM_IDS, 1));
        end
        send_word(OP_RECORD, id, PcW'($urandom), ValW'($urandom));
      end else if (pick < 58) begin
        send_word(OP_UPDATE, id, pc, ValW'($urandom));
      end else if (pick < 78) begin
        send_word(OP_LOOKUP, IdW'($urandom), pc, ValW'($urandom));
      end else if (pick < 93) begin
        send_word(OP_RETIRE, id, PcW'($urandom), ValW'($urandom));
      end else begin
        send_word(FuncW'($urandom), IdW'($urandom), PcW'($urandom), ValW'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_request = 200;
    repeat (24) begin
      send_word(FuncW'($urandom_range(OP_LOOKUP)), IdW'($urandom_range(NUM_IDS)),
                PcW'($urandom), ValW'($urandom));
    end
  endtask

  // Result checker and receiver-side stall control
  initial begin
    branch_rsp_t want;
    int          hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_ch.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_ch.ok);
            mismatches++;
          end
          if (out_ch.given_id !== want.given_id) begin
            $error("given_id: expected %0d, got %0d", want.given_id, out_ch.given_id);
            mismatches++;
          end
          if (out_ch.found_value !== want.found_value) begin
            $error("found_value: expected %0h, got %0h", want.found_value,
                   out_ch.found_value);
            mismatches++;
          end
          if (out_ch.recent_id !== want.recent_id) begin
            $error("recent_id: expected %0d, got %0d", want.recent_id, out_ch.recent_id);
            mismatches++;
          end
        end
      end
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    mismatches   = 0;
    hold_request = 0;
    src_idle_pct = 21;
    snk_idle_pct = 53;
    for (int i = 0; i < NUM_IDS; i++) begin
      free_fifo[i] = IdW'(i + 1);
      in_flight[i] = '0;
      tgt_pc[i]    = '0;
      tgt_val[i]   = '0;
      tgt_vld[i]   = 1'b0;
    end
    free_cnt      = NUM_IDS;
    flight_cnt    = 0;
    last_recorded = NO_ID;

    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.func            <= '0;
    in_ch.branch_id       <= '0;
    in_ch.branch_pc       <= '0;
    in_ch.predicted_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rejects();
    test_alloc_exhaust();
    test_order_fill();
    test_table();
    test_random(600, 21, 53);
    test_backpressure();
    test_random(600, 53, 21);
    test_random(500, 0, 0);

    in_ch.valid <= 1'b0;
    wait_drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
